### hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the RTL folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### hw/rtl/pal_pkg.sv
// Types and constants shared by the positional array list files.
package pal_pkg;

   localparam int POS_W = 6;
   localparam int LEN_W = 7;
   localparam int VAL_W = 32;
   localparam int OP_W  = 2;
   localparam int ST_W  = 2;

   localparam logic [LEN_W-1:0] CAP_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [ST_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [ST_W-1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] element_value;
   } pal_cmd_type;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic signed [VAL_W-1:0] read_value;
      logic [LEN_W-1:0]        list_length;
   } pal_res_type;

endpackage

### hw/rtl/pal_req_if.sv
// Request channel: operation, position and value to insert.
interface pal_req_if;
   logic                             valid;
   logic                             ready;
   logic [pal_pkg::OP_W-1:0]         req_type;
   logic [pal_pkg::POS_W-1:0]        position;
   logic signed [pal_pkg::VAL_W-1:0] element_value;

   modport source (output valid, output req_type, output position, output element_value,
                   input ready);
   modport sink (input valid, input req_type, input position, input element_value,
                 output ready);
endinterface

### hw/rtl/pal_rsp_if.sv
// Response channel: status, read value and list length.
interface pal_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pal_pkg::ST_W-1:0]         status;
   logic signed [pal_pkg::VAL_W-1:0] read_value;
   logic [pal_pkg::LEN_W-1:0]        list_length;

   modport source (output valid, output status, output read_value, output list_length,
                   input ready);
   modport sink (input valid, input status, input read_value, input list_length,
                 output ready);
endinterface

### hw/rtl/pal_csr_if.sv
// Configuration write channel for the capacity register.
interface pal_csr_if;
   logic                       valid;
   logic                       ready;
   logic [pal_pkg::LEN_W-1:0]  capacity_in_use;

   modport source (output valid, output capacity_in_use, input ready);
   modport sink (input valid, input capacity_in_use, output ready);
endinterface

### hw/rtl/pal_core.sv
// List engine: element store memory, entry count and the shift sequencer.
module pal_core #(
   parameter int MAX_DEPTH  = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  pal_pkg::pal_cmd_type       cmd,
   input  logic [pal_pkg::LEN_W-1:0]  capacity,
   output logic                       idle,
   output logic                       res_valid,
   output pal_pkg::pal_res_type       res,
   input  logic                       res_take
);
   import pal_pkg::*;

   localparam int AW = $clog2(MAX_DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SHIFT  = 5'b00010,
      ST_FETCH  = 5'b00100,
      ST_FINISH = 5'b01000,
      ST_DONE   = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [LEN_W-1:0]      count_ff, count_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [LEN_W-1:0]      pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [LEN_W-1:0]      src_ff, src_in;
   logic [LEN_W-1:0]      dst_ff, dst_in;
   logic [LEN_W-1:0]      rem_ff, rem_in;
   logic                  pend_ff, pend_in;
   pal_res_type           res_ff, res_in;

   logic [DATA_WIDTH-1:0] store_mem [MAX_DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  mem_re;
   logic                  mem_we;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   logic                  full;
   logic [LEN_W-1:0]      pos_ext;

   assign pos_ext   = LEN_W'(cmd.position);
   assign full      = (count_ff >= capacity) || (int'(count_ff) >= MAX_DEPTH);
   assign idle      = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

   // Reads and writes never meet on one entry: during a shift every write lands
   // on an entry that the remaining reads have already passed.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      op_in    = op_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      rem_in   = rem_ff;
      pend_in  = pend_ff;
      res_in   = res_ff;
      mem_re   = 1'b0;
      mem_we   = 1'b0;
      rd_addr  = '0;
      wr_addr  = '0;
      wr_data  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in              = cmd.op;
               pos_in             = pos_ext;
               val_in             = DATA_WIDTH'($unsigned(cmd.element_value));
               pend_in            = 1'b0;
               res_in.status      = STATUS_RANGE;
               res_in.read_value  = '0;
               res_in.list_length = count_ff;
               state_in           = ST_DONE;
               case (cmd.op)
                  OP_INSERT: begin
                     if (full) begin
                        res_in.status = STATUS_FULL;
                     end else if (pos_ext <= count_ff) begin
                        src_in   = count_ff - 1'b1;
                        rem_in   = count_ff - pos_ext;
                        state_in = ST_SHIFT;
                     end
                  end
                  OP_REMOVE: begin
                     if (pos_ext < count_ff) begin
                        src_in   = pos_ext + 1'b1;
                        rem_in   = count_ff - pos_ext - 1'b1;
                        state_in = ST_SHIFT;
                     end
                  end
                  OP_READ: begin
                     if (pos_ext < count_ff) begin
                        mem_re   = 1'b1;
                        rd_addr  = AW'(pos_ext);
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            res_in.status     = STATUS_OK;
            res_in.read_value = VAL_W'($signed(rd_data_ff));
            state_in          = ST_DONE;
         end
         ST_SHIFT: begin
            if (pend_ff) begin
               mem_we  = 1'b1;
               wr_addr = AW'(dst_ff);
               wr_data = rd_data_ff;
            end
            if (rem_ff != '0) begin
               mem_re  = 1'b1;
               rd_addr = AW'(src_ff);
               rem_in  = rem_ff - 1'b1;
               pend_in = 1'b1;
               if (op_ff == OP_INSERT) begin
                  dst_in = src_ff + 1'b1;
                  src_in = src_ff - 1'b1;
               end else begin
                  dst_in = src_ff - 1'b1;
                  src_in = src_ff + 1'b1;
               end
            end else begin
               pend_in  = 1'b0;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (op_ff == OP_INSERT) begin
               mem_we   = 1'b1;
               wr_addr  = AW'(pos_ff);
               wr_data  = val_ff;
               count_in = count_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
            end
            res_in.status      = STATUS_OK;
            res_in.read_value  = '0;
            res_in.list_length = count_in;
            state_in           = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
      src_ff <= src_in;
      dst_ff <= dst_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= store_mem[rd_addr];
      end
      if (mem_we) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

endmodule

### hw/rtl/positional_array_list.sv
// Top level of the positional array list with its capacity register and output stage.
//
// An ordered list of up to MAX_DEPTH signed words kept in one synchronous memory.
// Insert, remove and read act on a list position; each request beat yields one
// response beat with a status, the read value and the new length. One request is
// in work at a time. A read passes through the fetch state and a refused request
// goes straight to the done state; from the done state the response moves into the
// output register. An insert or remove at position p in a list of n entries walks
// the later entries through the memory one entry per cycle in the shift state and
// ends in the finish state. The next request is taken as soon as the response sits
// in the output register. Capacity writes are taken at any time but are meant for when the list is idle.
module positional_array_list #(
   parameter int MAX_DEPTH  = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   pal_req_if.sink   req_if,
   pal_rsp_if.source rsp_if,
   pal_csr_if.sink   csr_if
);
   import pal_pkg::*;

   logic [LEN_W-1:0] capacity_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   pal_res_type      rsp_res_ff;

   pal_cmd_type      cmd;
   logic             core_idle;
   logic             core_res_valid;
   pal_res_type      core_res;
   logic             res_take;
   logic             start;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = core_idle;
   assign start        = req_if.valid && core_idle;

   assign cmd.op            = req_if.req_type;
   assign cmd.position      = req_if.position;
   assign cmd.element_value = req_if.element_value;

   assign res_take     = core_res_valid && (!rsp_valid_ff || rsp_if.ready);
   assign rsp_valid_in = res_take || (rsp_valid_ff && !rsp_if.ready);

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_res_ff.status;
   assign rsp_if.read_value  = rsp_res_ff.read_value;
   assign rsp_if.list_length = rsp_res_ff.list_length;

   pal_core #(
      .MAX_DEPTH  (MAX_DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_pal_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .capacity  (capacity_ff),
      .idle      (core_idle),
      .res_valid (core_res_valid),
      .res       (core_res),
      .res_take  (res_take)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid) begin
            capacity_ff <= csr_if.capacity_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_res_ff <= core_res;
      end
   end

endmodule

### hw/rtl/pal_checker.sv
// Port checker for the positional array list and its bind to the top level.
`include "assert_macros.svh"

module pal_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [pal_pkg::ST_W-1:0]         rsp_status,
   input logic signed [pal_pkg::VAL_W-1:0] rsp_read_value,
   input logic [pal_pkg::LEN_W-1:0]        rsp_list_length
);
   import pal_pkg::*;

   logic [LEN_W-1:0] prev_len_ff;
   logic             rsp_beat;

   assign rsp_beat = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_len_ff <= '0;
      end else if (rsp_beat) begin
         prev_len_ff <= rsp_list_length;
      end
   end

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_read_value) && $stable(rsp_list_length), "Response beat changed while stalled.")
   `ASSERT_NEVER(a_value_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK && rsp_read_value != '0, "Failed request returned a nonzero value.")
   `ASSERT_CLK(a_len_step, clock, reset, rsp_beat |-> rsp_list_length == prev_len_ff || rsp_list_length == prev_len_ff + 1'b1 || rsp_list_length + 1'b1 == prev_len_ff, "List length moved by more than one entry.")
   `ASSERT_CLK(a_len_kept, clock, reset, rsp_beat && rsp_status != STATUS_OK |-> rsp_list_length == prev_len_ff, "Failed request changed the list length.")

endmodule

bind positional_array_list pal_checker u_pal_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_status      (rsp_if.status),
   .rsp_read_value  (rsp_if.read_value),
   .rsp_list_length (rsp_if.list_length)
);

### tb/tb_positional_array_list.sv
`timescale 1ns / 1ps
// Self-checking testbench for the positional array list, checked against a shadow copy of the list.
module tb_positional_array_list;
   import pal_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int DEPTH        = 64;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   pal_req_if req_bus();
   pal_rsp_if rsp_bus();
   pal_csr_if csr_bus();

   positional_array_list #(.MAX_DEPTH(DEPTH), .DATA_WIDTH(VAL_W)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   logic signed [VAL_W-1:0] shadow_list [DEPTH];
   int                      shadow_count = 0;
   logic [LEN_W-1:0]        shadow_cap = CAP_RESET;
   pal_res_type             pending_results [$];
   int                      error_count = 0;
   int                      quiet_cycles = 0;
   bit                      idle_on = 1'b1;
   int                      rsp_hold = 0;

   function automatic pal_res_type list_predict(input logic [OP_W-1:0] op,
                                                input logic [POS_W-1:0] pos,
                                                input logic signed [VAL_W-1:0] value);
      pal_res_type res;
      int          limit;
      int          p;
      limit = (shadow_cap > DEPTH) ? DEPTH : int'(shadow_cap);
      p = int'(pos);
      res.status = STATUS_RANGE;
      res.read_value = '0;
      case (op)
         OP_INSERT: begin
            if (shadow_count >= limit) begin
               res.status = STATUS_FULL;
            end else if (p <= shadow_count && shadow_count < DEPTH) begin
               for (int i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
               shadow_list[p] = value;
               shadow_count++;
               res.status = STATUS_OK;
            end
         end
         OP_REMOVE: begin
            if (p < shadow_count) begin
               for (int i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
               shadow_count--;
               res.status = STATUS_OK;
            end
         end
         OP_READ: begin
            if (p < shadow_count) begin
               res.read_value = shadow_list[p];
               res.status = STATUS_OK;
            end
         end
         default: ;
      endcase
      res.list_length = shadow_count[LEN_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("ERROR %s: got 0x%0h, expected 0x%0h", what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : beat_monitor
      pal_res_type want;
      bit          moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            shadow_cap = csr_bus.capacity_in_use;
            moved = 1'b1;
         end
         if (req_bus.valid && req_bus.ready) begin
            pending_results.push_back(list_predict(req_bus.req_type, req_bus.position,
                                                   req_bus.element_value));
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            if (pending_results.size() == 0) begin
               report_mismatch("response beat with nothing pending", 64'(rsp_bus.status),
                               64'd0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", 64'(rsp_bus.status), 64'(want.status));
               if (rsp_bus.read_value !== want.read_value)
                  report_mismatch("read_value", 64'(rsp_bus.read_value),
                                  64'(want.read_value));
               if (rsp_bus.list_length !== want.list_length)
                  report_mismatch("list_length", 64'(rsp_bus.list_length),
                                  64'(want.list_length));
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin : response_sink
      int burst;
      burst = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold--;
         end else if (burst > 0) begin
            rsp_bus.ready <= 1'b0;
            burst--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(0, 3);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_cmd(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] value);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 4);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.req_type      <= op;
      req_bus.position      <= pos;
      req_bus.element_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic release_req();
      req_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_list_idle();
      release_req();
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [LEN_W-1:0] cap);
      wait_list_idle();
      csr_bus.valid           <= 1'b1;
      csr_bus.capacity_in_use <= cap;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic signed [VAL_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return '0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_random(input int count, input int ins_pct, input int rem_pct);
      logic [OP_W-1:0]  op;
      logic [POS_W-1:0] pos;
      int               r;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 2) op = OP_UNUSED;
         else if (r < 2 + ins_pct) op = OP_INSERT;
         else if (r < 2 + ins_pct + rem_pct) op = OP_REMOVE;
         else op = OP_READ;
         if ($urandom_range(0, 99) < 15)
            pos = POS_W'($urandom_range(0, DEPTH - 1));
         else if (op == OP_INSERT)
            pos = POS_W'($urandom_range(0, (shadow_count > DEPTH - 1) ? DEPTH - 1
                                                                     : shadow_count));
         else
            pos = (shadow_count == 0) ? '0 : POS_W'($urandom_range(0, shadow_count - 1));
         send_cmd(op, pos, pick_value());
      end
   endtask

   task automatic test_empty_list();
      send_cmd(OP_READ, 6'd0, 32'sd0);
      send_cmd(OP_REMOVE, 6'd0, 32'sd0);
      send_cmd(OP_UNUSED, 6'd0, 32'sd0);
      send_cmd(OP_INSERT, 6'd1, 32'sd5);
      release_req();
   endtask

   task automatic test_edit_and_read();
      send_cmd(OP_INSERT, 6'd0, 32'sh7fffffff);
      send_cmd(OP_INSERT, 6'd1, 32'sh80000000);
      send_cmd(OP_INSERT, 6'd0, -32'sd1);
      send_cmd(OP_INSERT, 6'd2, 32'sd0);
      send_cmd(OP_INSERT, 6'd63, 32'sh12345678);
      for (int i = 0; i < 4; i++) send_cmd(OP_READ, i[POS_W-1:0], 32'sd0);
      send_cmd(OP_READ, 6'd4, 32'sd0);
      send_cmd(OP_READ, 6'd63, 32'sd0);
      send_cmd(OP_REMOVE, 6'd1, 32'sd0);
      send_cmd(OP_READ, 6'd1, 32'sd0);
      send_cmd(OP_REMOVE, 6'd2, 32'sd0);
      send_cmd(OP_UNUSED, 6'd63, -32'sd1);
      release_req();
   endtask

   task automatic test_capacity_rules();
      // The list holds two entries here, so a capacity of two makes it full at once.
      write_capacity(7'd2);
      send_cmd(OP_INSERT, 6'd0, 32'sd11);
      send_cmd(OP_INSERT, 6'd63, 32'sd12);
      send_cmd(OP_READ, 6'd1, 32'sd0);
      send_cmd(OP_REMOVE, 6'd0, 32'sd0);
      send_cmd(OP_INSERT, 6'd0, 32'sd13);
      write_capacity(7'd1);
      send_cmd(OP_INSERT, 6'd0, 32'sd14);
      send_cmd(OP_READ, 6'd0, 32'sd0);
      write_capacity(7'd0);
      send_cmd(OP_INSERT, 6'd0, 32'sd15);
      send_cmd(OP_REMOVE, 6'd1, 32'sd0);
      send_cmd(OP_REMOVE, 6'd0, 32'sd0);
      write_capacity(7'd127);
      send_cmd(OP_INSERT, 6'd0, 32'sd16);
      release_req();
   endtask

   task automatic test_random_mix();
      logic [LEN_W-1:0] caps [9] = '{7'd64, 7'd1, 7'd3, 7'd9, 7'd33, 7'd0, 7'd127,
                                     7'd64, 7'd64};
      caps[8] = LEN_W'($urandom_range(1, 64));
      for (int idx = 0; idx < 9; idx++) begin
         write_capacity(caps[idx]);
         if (caps[idx] == 7'd127) run_random(120, 85, 5);
         run_random(80, 60, 20);
         run_random(80, 20, 55);
      end
      release_req();
   endtask

   task automatic test_backpressure();
      write_capacity(7'd64);
      rsp_hold = 300;
      for (int k = 0; k < 10; k++)
         send_cmd(($urandom_range(0, 1) == 0) ? OP_INSERT : OP_READ, 6'd0, pick_value());
      release_req();
   endtask

   task automatic test_quiet_finish();
      idle_on = 1'b0;
      write_capacity(LEN_W'($urandom_range(1, 64)));
      run_random(100, 55, 25);
      run_random(60, 20, 55);
      release_req();
   endtask

   initial begin
      req_bus.valid           = 1'b0;
      req_bus.req_type        = OP_INSERT;
      req_bus.position        = '0;
      req_bus.element_value   = '0;
      csr_bus.valid           = 1'b0;
      csr_bus.capacity_in_use = CAP_RESET;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_empty_list();
      test_edit_and_read();
      test_capacity_rules();
      test_random_mix();
      test_backpressure();
      test_quiet_finish();
      wait_list_idle();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/pal_pkg.sv
hw/rtl/pal_req_if.sv
hw/rtl/pal_rsp_if.sv
hw/rtl/pal_csr_if.sv
hw/rtl/pal_core.sv
hw/rtl/positional_array_list.sv
hw/rtl/pal_checker.sv
tb/tb_positional_array_list.sv
